@@ hdl/rrsd_pkg.sv @@
// Shared constants and types for the round-robin server dispatch block.
`default_nettype none

package rrsd_pkg;

	// Server pool and counter sizing
	localparam int MAX_SERVERS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int K_W         = $clog2(MAX_SERVERS + 1);

	// Field widths fixed by the interface
	localparam int CFG_W  = 5;
	localparam int TIME_W = 31;
	localparam int BUSY_W = TIME_W + 1;

	localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [K_W-1:0]         kcnt_t;
	typedef logic [TIME_W-1:0]      time_t;
	typedef logic [BUSY_W-1:0]      busy_t;
	typedef logic [COUNT_BITS-1:0]  cnt_t;
	typedef logic [MAX_SERVERS-1:0] mask_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

`default_nettype wire

@@ hdl/rrsd_if.sv @@
// Valid/ready channel interfaces for requests and dispatch results.
`default_nettype none

interface rrsd_req_if;
	logic                 valid;
	logic                 ready;
	rrsd_pkg::time_t      arrival_time;
	rrsd_pkg::time_t      load_time;

	modport source (output valid, output arrival_time, output load_time, input ready);
	modport sink   (input valid, input arrival_time, input load_time, output ready);
endinterface

interface rrsd_rsp_if;
	logic                 valid;
	logic                 ready;
	logic                 accepted;
	rrsd_pkg::idx_t       server_index;
	rrsd_pkg::cnt_t       server_count;
	rrsd_pkg::cnt_t       busiest_count;
	rrsd_pkg::mask_t      busiest_mask;

	modport source (output valid, output accepted, output server_index, output server_count,
		output busiest_count, output busiest_mask, input ready);
	modport sink   (input valid, input accepted, input server_index, input server_count,
		input busiest_count, input busiest_mask, output ready);
endinterface

`default_nettype wire

@@ hdl/round_robin_server_dispatch.sv @@
// Round-robin dispatch of requests to the first free server, state held in memories.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------------------
//   req      | in        | arrival_time, load_time
//   rsp      | out       | accepted, server_index, server_count, busiest_count, busiest_mask
//   cfg      | in        | servers_in_use (write enable + data, no read-back)
//
// A request scans from 1 up to the clamped server count (1..16) of servers, stopping at the
// first free one: the scan reads one server's busy-until/count entry per cycle from the memories.
// Reset is asynchronous and active low; per-entry valid bits make every server read as
// free with a zero count after reset, with no clearing pass.
// The result sits in an output register; the next request is taken while it waits.
// A finished scan holds while that register is still occupied.
`default_nettype none

module round_robin_server_dispatch (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rrsd_pkg::CFG_W-1:0] cfg_wdata,
	rrsd_req_if.sink                        req,
	rrsd_rsp_if.source                      rsp
);

	// State memories and per-entry valid bits
	rrsd_pkg::busy_t busy_mem [rrsd_pkg::MAX_SERVERS];
	rrsd_pkg::cnt_t  cnt_mem  [rrsd_pkg::MAX_SERVERS];
	rrsd_pkg::mask_t vld_q;

	rrsd_pkg::state_t state_q, state_d;
	logic [rrsd_pkg::CFG_W-1:0] cfg_q;
	rrsd_pkg::idx_t  sp_q;
	rrsd_pkg::idx_t  cur_q;
	rrsd_pkg::idx_t  step_q;
	rrsd_pkg::time_t arr_q;
	rrsd_pkg::time_t load_q;
	rrsd_pkg::cnt_t  best_q;
	rrsd_pkg::mask_t mask_q;

	// Registered memory read data
	rrsd_pkg::busy_t rd_busy_s1;
	rrsd_pkg::cnt_t  rd_cnt_s1;
	logic            rd_vld_s1;

	// Output register
	logic            out_valid_q;
	logic            out_acc_q;
	rrsd_pkg::idx_t  out_idx_q;
	rrsd_pkg::cnt_t  out_cnt_q;
	rrsd_pkg::cnt_t  out_best_q;
	rrsd_pkg::mask_t out_mask_q;

	rrsd_pkg::kcnt_t k_eff;
	rrsd_pkg::idx_t  k_m1;
	rrsd_pkg::idx_t  p_start;
	rrsd_pkg::idx_t  next_idx;
	rrsd_pkg::idx_t  rd_addr;
	logic            req_xfer;
	logic            out_free;
	logic            is_free;
	logic            is_last;
	logic            finish;
	logic            advance;
	rrsd_pkg::cnt_t  cnt_new;
	rrsd_pkg::cnt_t  best_d;
	rrsd_pkg::mask_t mask_d;
	rrsd_pkg::mask_t pick_bit;
	rrsd_pkg::busy_t busy_new;

	// Clamp the configured server count into 1..MAX_SERVERS
	always_comb begin
		if (cfg_q == '0) begin
			k_eff = rrsd_pkg::kcnt_t'(1);
		end else if (int'(cfg_q) > rrsd_pkg::MAX_SERVERS) begin
			k_eff = rrsd_pkg::kcnt_t'(rrsd_pkg::MAX_SERVERS);
		end else begin
			k_eff = rrsd_pkg::kcnt_t'(cfg_q);
		end
		k_m1     = rrsd_pkg::idx_t'(k_eff - rrsd_pkg::kcnt_t'(1));
		p_start  = (rrsd_pkg::kcnt_t'(sp_q) < k_eff) ? sp_q : '0;
		next_idx = (cur_q == k_m1) ? '0 : rrsd_pkg::idx_t'(cur_q + rrsd_pkg::idx_t'(1));
	end

	// Scan decision and best-count update
	always_comb begin
		req_xfer = req.valid && req.ready;
		out_free = !out_valid_q || rsp.ready;
		is_free  = !rd_vld_s1 || (rd_busy_s1 <= {1'b0, arr_q});
		is_last  = (step_q == k_m1);
		cnt_new  = (rd_vld_s1 ? rd_cnt_s1 : '0);
		if (cnt_new != rrsd_pkg::CNT_TOP) begin
			cnt_new = cnt_new + rrsd_pkg::cnt_t'(1);
		end
		busy_new = rrsd_pkg::busy_t'({1'b0, arr_q} + {1'b0, load_q});
		pick_bit = rrsd_pkg::mask_t'(1) << cur_q;
		best_d   = best_q;
		mask_d   = mask_q;
		if (is_free) begin
			if (cnt_new > best_q) begin
				best_d = cnt_new;
				mask_d = pick_bit;
			end else if (cnt_new == best_q) begin
				mask_d = mask_q | pick_bit;
			end
		end

		finish  = 1'b0;
		advance = 1'b0;
		state_d = state_q;
		rd_addr = cur_q;
		unique case (state_q)
			rrsd_pkg::ST_IDLE: begin
				rd_addr = p_start;
				if (req_xfer) begin
					state_d = rrsd_pkg::ST_SCAN;
				end
			end
			rrsd_pkg::ST_SCAN: begin
				if (is_free || is_last) begin
					if (out_free) begin
						finish  = 1'b1;
						state_d = rrsd_pkg::ST_IDLE;
					end
				end else begin
					advance = 1'b1;
					rd_addr = next_idx;
				end
			end
			default: begin
				state_d = rrsd_pkg::ST_IDLE;
			end
		endcase
	end

	assign req.ready         = (state_q == rrsd_pkg::ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.accepted      = out_acc_q;
	assign rsp.server_index  = out_idx_q;
	assign rsp.server_count  = out_cnt_q;
	assign rsp.busiest_count = out_best_q;
	assign rsp.busiest_mask  = out_mask_q;

	// Memories: one read and one write per cycle; the write of a request lands before
	// the next request's first read, so no forwarding is needed
	always_ff @(posedge clk) begin
		rd_busy_s1 <= busy_mem[rd_addr];
		rd_cnt_s1  <= cnt_mem[rd_addr];
		if (finish && is_free) begin
			busy_mem[cur_q] <= busy_new;
			cnt_mem[cur_q]  <= cnt_new;
		end
	end

	// Request payload, held for the scan
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			arr_q  <= req.arrival_time;
			load_q <= req.load_time;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (finish) begin
			out_acc_q  <= is_free;
			out_idx_q  <= is_free ? cur_q : '0;
			out_cnt_q  <= is_free ? cnt_new : '0;
			out_best_q <= best_d;
			out_mask_q <= mask_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrsd_pkg::ST_IDLE;
			cfg_q       <= rrsd_pkg::CFG_W'(rrsd_pkg::MAX_SERVERS);
			sp_q        <= '0;
			cur_q       <= '0;
			step_q      <= '0;
			best_q      <= '0;
			mask_q      <= '0;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= vld_q[rd_addr];
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			// Start a scan at the pointer and advance the pointer
			if (req_xfer) begin
				cur_q  <= p_start;
				step_q <= '0;
				sp_q   <= (p_start == k_m1) ? '0 : rrsd_pkg::idx_t'(p_start + rrsd_pkg::idx_t'(1));
			end
			if (advance) begin
				cur_q  <= next_idx;
				step_q <= rrsd_pkg::idx_t'(step_q + rrsd_pkg::idx_t'(1));
			end
			if (finish) begin
				best_q <= best_d;
				mask_q <= mask_d;
				if (is_free) begin
					vld_q[cur_q] <= 1'b1;
				end
			end
			// Output register: load on finish, drop on transfer
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ bench/dispatch_checker.sv @@
// Checker that predicts and compares every result of the round-robin server dispatch block.
`timescale 1ns / 1ps

module dispatch_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rrsd_pkg::CFG_W-1:0] cfg_wdata,
	rrsd_req_if                             req,
	rrsd_rsp_if                             rsp,
	output int unsigned                     mismatch_count,
	output int unsigned                     pending
);

	// One dispatch decision as it leaves the block
	typedef struct packed {
		logic            accepted;
		rrsd_pkg::idx_t  server_index;
		rrsd_pkg::cnt_t  server_count;
		rrsd_pkg::cnt_t  busiest_count;
		rrsd_pkg::mask_t busiest_mask;
	} dispatch_t;

	// Shadow of the server pool
	rrsd_pkg::busy_t            server_busy_until [rrsd_pkg::MAX_SERVERS];
	rrsd_pkg::cnt_t             server_handled    [rrsd_pkg::MAX_SERVERS];
	int                         next_start;
	rrsd_pkg::cnt_t             top_count;
	rrsd_pkg::mask_t            top_mask;
	logic [rrsd_pkg::CFG_W-1:0] pool_setting;

	dispatch_t        expected_dispatches [$];
	dispatch_t        oldest;
	dispatch_t        predicted;
	int unsigned      results_seen;
	int               server_i;

	// Work out one dispatch decision and update the shadow pool
	function automatic dispatch_t predict_dispatch(input rrsd_pkg::time_t arrival,
			input rrsd_pkg::time_t load);
		int              pool;
		int              first;
		int              slot;
		int              pick;
		int              i;
		logic            found;
		rrsd_pkg::cnt_t  count;
		rrsd_pkg::mask_t pick_bit;
		dispatch_t       res;
		pool = (pool_setting == 0) ? 1 :
			(pool_setting > rrsd_pkg::MAX_SERVERS) ? rrsd_pkg::MAX_SERVERS : int'(pool_setting);
		// a pointer left beyond a shrunken pool restarts at server 0
		first = (next_start < pool) ? next_start : 0;
		found = 1'b0;
		pick  = 0;
		// scan in circular order from the pointer for the first free server
		for (i = 0; i < pool; i++) begin
			slot = first + i;
			if (slot >= pool)
				slot -= pool;
			if (!found && server_busy_until[slot] <= rrsd_pkg::busy_t'(arrival)) begin
				found = 1'b1;
				pick  = slot;
			end
		end
		res = '0;
		if (found) begin
			// count saturates; a saturated server still joins the busiest mask
			count = server_handled[pick];
			if (count != rrsd_pkg::CNT_TOP)
				count++;
			server_handled[pick]    = count;
			server_busy_until[pick] = rrsd_pkg::busy_t'(arrival) + rrsd_pkg::busy_t'(load);
			pick_bit = rrsd_pkg::mask_t'(1) << pick;
			if (count > top_count) begin
				top_count = count;
				top_mask  = pick_bit;
			end else if (count == top_count) begin
				top_mask |= pick_bit;
			end
			res.accepted     = 1'b1;
			res.server_index = rrsd_pkg::idx_t'(pick);
			res.server_count = count;
		end
		// advance the pointer whether served or dropped
		next_start = (first + 1 >= pool) ? 0 : first + 1;
		res.busiest_count = top_count;
		res.busiest_mask  = top_mask;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns: result %0d: %s", $time, results_seen, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (server_i = 0; server_i < rrsd_pkg::MAX_SERVERS; server_i++) begin
				server_busy_until[server_i] = '0;
				server_handled[server_i]    = '0;
			end
			next_start   = 0;
			top_count    = '0;
			top_mask     = '0;
			pool_setting = rrsd_pkg::CFG_W'(rrsd_pkg::MAX_SERVERS);
			expected_dispatches.delete();
			results_seen   = 0;
			mismatch_count = 0;
			pending        = 0;
		end else begin
			// compare a result transfer with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_dispatches.size() == 0) begin
					report_mismatch("result transfer with no request outstanding");
				end else begin
					oldest = expected_dispatches.pop_front();
					check_field("accepted", rsp.accepted, oldest.accepted);
					check_field("server_index", rsp.server_index, oldest.server_index);
					check_field("server_count", rsp.server_count, oldest.server_count);
					check_field("busiest_count", rsp.busiest_count, oldest.busiest_count);
					check_field("busiest_mask", rsp.busiest_mask, oldest.busiest_mask);
				end
			end
			// predict the result of a request transfer and queue it at the tail
			if (req.valid && req.ready) begin
				predicted = predict_dispatch(req.arrival_time, req.load_time);
				expected_dispatches = {expected_dispatches, predicted};
			end
			// track the pool size register
			if (cfg_we)
				pool_setting = cfg_wdata;
			pending = expected_dispatches.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the round-robin server dispatch block: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int              RESET_CYCLES   = 4;
	localparam int              DRAIN_CYCLES   = 24;
	localparam int              STALL_LIMIT    = 5000;
	localparam int              HOLD_CYCLES    = 300;
	localparam int              SOLO_ITEMS     = 64;
	localparam int              PHASE_ITEMS    = 100;
	localparam int              PHASE_COUNT    = 10;
	localparam int              PRESSURE_PHASE = 6;
	localparam rrsd_pkg::time_t TIME_MAX       = '1;

	// Pool sizes for the random phases: zero and oversize settings included
	localparam logic [rrsd_pkg::CFG_W-1:0] POOL_PLAN [PHASE_COUNT] =
		'{5'd2, 5'd0, 5'd31, 5'd7, 5'd3, 5'd17, 5'd16, 5'd12, 5'd1, 5'd5};

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_PERIODIC,
		RX_COIN
	} rx_mode_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [rrsd_pkg::CFG_W-1:0] cfg_wdata;
	int unsigned                mismatch_count;
	int unsigned                pending;

	// Sender state
	rrsd_pkg::time_t request_clock;
	int              burst_left;
	logic            gapless;
	int              hold_requests = 0;

	rrsd_req_if req_ch ();
	rrsd_rsp_if rsp_ch ();

	round_robin_server_dispatch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	dispatch_checker dispatch_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always #5 clk = ~clk;

	// Offer one request; idle between bursts unless the sender runs gapless
	task automatic send_request(input rrsd_pkg::time_t arrival, input rrsd_pkg::time_t load);
		int gap;
		if (!gapless && burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		req_ch.valid        <= 1'b1;
		req_ch.arrival_time <= arrival;
		req_ch.load_time    <= load;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		burst_left--;
	endtask

	// Write the pool size once every result is out and the block has settled
	task automatic set_servers(input logic [rrsd_pkg::CFG_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly rising arrivals with loads scaled to the pool, plus leaps and long loads
	task automatic random_requests(input int count, input logic [rrsd_pkg::CFG_W-1:0] setting);
		int              pool;
		int              roll;
		int              i;
		rrsd_pkg::time_t load;
		pool = (setting == 0) ? 1 :
			(setting > rrsd_pkg::MAX_SERVERS) ? rrsd_pkg::MAX_SERVERS : int'(setting);
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				request_clock = request_clock +
					rrsd_pkg::time_t'($urandom_range(0, TIME_MAX - request_clock));
			else if (roll < 4)
				request_clock = rrsd_pkg::time_t'($urandom);
			else if (request_clock > TIME_MAX - 6)
				request_clock = TIME_MAX;
			else
				request_clock = request_clock + rrsd_pkg::time_t'($urandom_range(0, 6));
			roll = $urandom_range(0, 99);
			if (roll < 4)
				load = rrsd_pkg::time_t'($urandom_range(0, TIME_MAX - request_clock));
			else if (roll < 10)
				load = '0;
			else
				load = rrsd_pkg::time_t'($urandom_range(0, 6 * pool));
			send_request(request_clock, load);
		end
	endtask

	// Stimulus and verdict
	initial begin : stimulus
		int i;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.arrival_time <= '0;
		req_ch.load_time    <= '0;
		request_clock = '0;
		burst_left    = 0;
		gapless       = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill every server, drop while all are busy, serve once one frees exactly
		send_request(0, 0);
		for (i = 0; i < rrsd_pkg::MAX_SERVERS; i++)
			send_request(10, 100);
		send_request(10, 0);
		send_request(109, 0);
		send_request(110, TIME_MAX);
		send_request(111, 0);

		// single server with a stale pointer, driven back to back
		set_servers(5'd1);
		gapless = 1'b1;
		for (i = 0; i < SOLO_ITEMS; i++)
			send_request(200, 0);
		gapless = 1'b0;

		// random phases; one holds off the receiver while the sender keeps offering
		request_clock = 200;
		for (i = 0; i < PHASE_COUNT; i++) begin
			set_servers(POOL_PLAN[i]);
			if (i == PRESSURE_PHASE) begin
				gapless = 1'b1;
				hold_requests++;
			end
			random_requests(PHASE_ITEMS, POOL_PLAN[i]);
			gapless = 1'b0;
		end

		// top of the time range
		set_servers(5'd16);
		for (i = 0; i < 3; i++)
			send_request(TIME_MAX, TIME_MAX);
		send_request(TIME_MAX, 0);

		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: stall pattern is redrawn at random from four modes; long hold on request
	initial begin : receiver
		rx_mode_t    mode;
		int          mode_left;
		int          hold_left;
		int          hold_seen;
		int unsigned tick;
		mode      = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		tick      = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS:   rsp_ch.ready <= 1'b1;
					RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_PERIODIC: rsp_ch.ready <= ((tick % 7) >= 3);
					default:     rsp_ch.ready <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	// Watchdog: end the run if nothing transfers for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					cfg_we || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
